>>> design/jtbp_pkg.sv
`timescale 1ns / 1ps

package jtbp_pkg;

    localparam int CMD_W = 3;
    localparam int VAL_W = 64;
    localparam int WID_W = 7;
    localparam int CNT_W = 48;
    localparam int LEN_W = 7;   // segment length / remaining token bits (max 79)
    localparam int HDR_W = 18;  // prefix + mat header bits
    localparam int HLN_W = 5;   // header length (max 15)

    localparam logic [CMD_W-1:0] CMD_RAW     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_MAT     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ATOM    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CELL    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_BACKREF = 3'd4;
    localparam logic [CMD_W-1:0] CMD_FLUSH   = 3'd5;

    localparam logic [WID_W-1:0] RAW_MAX = 7'd64;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN1,
        ST_LEN2,
        ST_HDR,
        ST_BODY,
        ST_SEG,
        ST_FLUSH
    } st_t;

    // sequencer -> packing unit
    typedef struct packed {
        logic             load_seg;
        logic [VAL_W-1:0] seg_val;
        logic [LEN_W-1:0] seg_len;
        logic             load_rem;
        logic [LEN_W-1:0] rem;
        logic             step;
        logic             flush;
    } pk_ctl_t;

    // packing unit -> sequencer
    typedef struct packed {
        logic out_free;
        logic seg_last;
        logic off_zero;
    } pk_sts_t;

    function automatic logic [3:0] bitlen8(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (v[i])
            begin
                n = 4'(i + 1);
            end
        end
        return n;
    endfunction

    function automatic logic [2:0] bitlen7(input logic [6:0] v);
        logic [2:0] n;
        n = '0;
        for (int i = 0; i < 7; i++)
        begin
            if (v[i])
            begin
                n = 3'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

>>> design/jtbp_in_if.sv
`timescale 1ns / 1ps

interface jtbp_in_if import jtbp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] value;
    logic [WID_W-1:0] width;

    modport source (output valid, output cmd, output value, output width, input ready);
    modport sink   (input valid, input cmd, input value, input width, output ready);
endinterface

>>> design/jtbp_out_if.sv
`timescale 1ns / 1ps

interface jtbp_out_if import jtbp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [7:0]       out_byte;
    logic             last;
    logic             message_end;
    logic [CNT_W-1:0] bits_written;

    modport source (output valid, output out_byte, output last, output message_end,
                    output bits_written, input ready);
    modport sink   (input valid, input out_byte, input last, input message_end,
                    input bits_written, output ready);
endinterface

>>> design/jam_token_bit_packer.sv
`timescale 1ns / 1ps

// Token bit packer: serializer tokens in on "tok", LSB-first stream bytes
// out on "bstream". Both are valid/ready channels; a transaction moves on
// a clock edge with valid and ready high.
// Each token becomes at most two bit segments (a short header and a body),
// which one shared packing unit moves into the partial byte, up to the
// free bits of that byte per cycle while the output register can take a byte.
// A filled byte goes to the output register at the end of its packing cycle.
// The byte a token completes last carries last; a flush sends a nonempty
// partial byte, zero-padded, with last and message_end.
// Sequence: a raw or cell token loads its segment on accept, then packs
// one step per byte it touches. Mat, atom and backref tokens pass the
// two-stage bit length unit (ST_LEN1, ST_LEN2); ST_HDR builds and loads
// the header and ST_BODY loads a nonempty body; header and body are packed
// as separate segments. Flush waits until the partial byte is empty or
// the output register is free. tok.ready is high only while the sequencer
// is idle; a waiting output byte does not block acceptance. When bstream
// stalls, packing stops on the next step and resumes when the byte is
// taken; nothing is lost. Reset (rst_n low, asynchronous) empties the
// output register and clears the partial byte, bit offset and bit count.
module jam_token_bit_packer import jtbp_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    jtbp_in_if.sink    tok,
    jtbp_out_if.source bstream
);

    st_t              st_reg, st_next;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic             body_reg, body_next;

    pk_ctl_t          ctl;
    pk_sts_t          sts;
    logic [LEN_W-1:0] blen;

    logic             accept;
    logic [WID_W-1:0] raw_w;
    logic [2:0]       c;
    logic [15:0]      mat_hdr;
    logic [HDR_W-1:0] hdr_val;
    logic [HLN_W-1:0] hdr_len;

    jtbp_bitlen u_bitlen (
        .clk   (clk),
        .value (val_reg),
        .blen  (blen)
    );

    jtbp_pack u_pack (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .sts   (sts),
        .dout  (bstream)
    );

    assign tok.ready = (st_reg == ST_IDLE);
    assign accept    = tok.valid && tok.ready;
    assign raw_w     = (tok.width > RAW_MAX) ? RAW_MAX : tok.width;

    // header segment: tag prefix then mat header (c zeros, 1, low c-1 bits of b);
    // bits above the header length are never packed
    always_comb
    begin
        c       = bitlen7(blen);
        mat_hdr = 16'({blen, 1'b1}) << c;
        hdr_val = '0;
        hdr_len = '0;
        case (cmd_reg)
            CMD_MAT:
            begin
                if (blen == '0)
                begin
                    hdr_val = HDR_W'(1'b1);
                    hdr_len = HLN_W'(1);
                end
                else
                begin
                    hdr_val = HDR_W'(mat_hdr);
                    hdr_len = HLN_W'({c, 1'b0});
                end
            end
            CMD_ATOM:
            begin
                if (blen == '0)
                begin
                    hdr_val = HDR_W'(2'b10);
                    hdr_len = HLN_W'(2);
                end
                else
                begin
                    hdr_val = HDR_W'({mat_hdr, 1'b0});
                    hdr_len = HLN_W'({c, 1'b1});
                end
            end
            CMD_BACKREF:
            begin
                if (blen == '0)
                begin
                    hdr_val = HDR_W'(3'b111);
                    hdr_len = HLN_W'(3);
                end
                else
                begin
                    hdr_val = {mat_hdr, 2'b11};
                    hdr_len = HLN_W'({c, 1'b0}) + HLN_W'(2);
                end
            end
            default:
            begin
                hdr_val = '0;
                hdr_len = '0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (tok.cmd)
                        CMD_RAW:     st_next = (raw_w == '0) ? ST_IDLE : ST_SEG;
                        CMD_MAT:     st_next = ST_LEN1;
                        CMD_ATOM:    st_next = ST_LEN1;
                        CMD_BACKREF: st_next = ST_LEN1;
                        CMD_CELL:    st_next = ST_SEG;
                        CMD_FLUSH:   st_next = ST_FLUSH;
                        default:     st_next = ST_IDLE;
                    endcase
                end
            end
            ST_LEN1:  st_next = ST_LEN2;
            ST_LEN2:  st_next = ST_HDR;
            ST_HDR:   st_next = ST_SEG;
            ST_BODY:  st_next = ST_SEG;
            ST_SEG:
            begin
                if (sts.out_free && sts.seg_last)
                begin
                    st_next = body_reg ? ST_BODY : ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (sts.off_zero || sts.out_free)
                begin
                    st_next = ST_IDLE;
                end
            end
            default:  st_next = ST_IDLE;
        endcase
    end

    // unit control
    always_comb
    begin
        ctl = '0;
        case (st_reg)
            ST_IDLE:
            begin
                if (accept && (tok.cmd == CMD_RAW) && (raw_w != '0))
                begin
                    ctl.load_seg = 1'b1;
                    ctl.seg_val  = tok.value;
                    ctl.seg_len  = LEN_W'(raw_w);
                    ctl.load_rem = 1'b1;
                    ctl.rem      = LEN_W'(raw_w);
                end
                else if (accept && (tok.cmd == CMD_CELL))
                begin
                    ctl.load_seg = 1'b1;
                    ctl.seg_val  = VAL_W'(2'b01);
                    ctl.seg_len  = LEN_W'(2);
                    ctl.load_rem = 1'b1;
                    ctl.rem      = LEN_W'(2);
                end
            end
            ST_HDR:
            begin
                ctl.load_seg = 1'b1;
                ctl.seg_val  = VAL_W'(hdr_val);
                ctl.seg_len  = LEN_W'(hdr_len);
                ctl.load_rem = 1'b1;
                ctl.rem      = LEN_W'(hdr_len) + blen;
            end
            ST_BODY:
            begin
                ctl.load_seg = 1'b1;
                ctl.seg_val  = val_reg;
                ctl.seg_len  = blen;
            end
            ST_SEG:
            begin
                ctl.step = sts.out_free;
            end
            ST_FLUSH:
            begin
                ctl.flush = sts.off_zero || sts.out_free;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    // token registers
    always_comb
    begin
        cmd_next  = cmd_reg;
        val_next  = val_reg;
        body_next = body_reg;
        if (accept)
        begin
            cmd_next  = tok.cmd;
            body_next = 1'b0;
            if ((tok.cmd == CMD_MAT) || (tok.cmd == CMD_BACKREF))
            begin
                val_next = {32'd0, tok.value[31:0]};
            end
            else
            begin
                val_next = tok.value;
            end
        end
        if (st_reg == ST_HDR)
        begin
            body_next = (blen != '0);
        end
        if (st_reg == ST_BODY)
        begin
            body_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            cmd_reg  <= CMD_RAW;
            body_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            cmd_reg  <= cmd_next;
            body_reg <= body_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

>>> design/jtbp_bitlen.sv
`timescale 1ns / 1ps

// Two-stage bit length of a 64-bit word: highest nonzero byte, then bit
// length inside that byte.
module jtbp_bitlen import jtbp_pkg::*; (
    input  logic             clk,
    input  logic [VAL_W-1:0] value,
    output logic [LEN_W-1:0] blen
);

    logic [2:0]       hb;
    logic             nz;
    logic [7:0]       top_byte;
    logic [2:0]       hb_reg;
    logic             nz_reg;
    logic [7:0]       top_reg;
    logic [LEN_W-1:0] blen_next;
    logic [LEN_W-1:0] blen_reg;

    always_comb
    begin
        hb = '0;
        nz = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (value[8*i +: 8] != 8'd0)
            begin
                hb = 3'(i);
                nz = 1'b1;
            end
        end
        top_byte = value[{hb, 3'b000} +: 8];
    end

    always_comb
    begin
        if (nz_reg)
        begin
            blen_next = LEN_W'({hb_reg, 3'b000}) + LEN_W'(bitlen8(top_reg));
        end
        else
        begin
            blen_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        hb_reg   <= hb;
        nz_reg   <= nz;
        top_reg  <= top_byte;
        blen_reg <= blen_next;
    end

    assign blen = blen_reg;

endmodule

>>> design/jtbp_pack.sv
`timescale 1ns / 1ps

// Shared packing unit: moves up to one byte's worth of segment bits into
// the partial byte per step, and holds the output register.
module jtbp_pack import jtbp_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  pk_ctl_t    ctl,
    output pk_sts_t    sts,
    jtbp_out_if.source dout
);

    logic [7:0]       part_reg,    part_next;
    logic [2:0]       off_reg,     off_next;
    logic [CNT_W-1:0] cnt_reg,     cnt_next;
    logic [VAL_W-1:0] seg_val_reg, seg_val_next;
    logic [LEN_W-1:0] seg_len_reg, seg_len_next;
    logic [LEN_W-1:0] rem_reg,     rem_next;
    logic             ov_reg,      ov_next;
    logic [7:0]       ob_reg,      ob_next;
    logic             ol_reg,      ol_next;
    logic             oe_reg,      oe_next;
    logic [CNT_W-1:0] obw_reg,     obw_next;

    logic [3:0]       room;
    logic [3:0]       n;
    logic [7:0]       mask;
    logic [7:0]       ins;
    logic [7:0]       part_new;
    logic [3:0]       off_sum;
    logic [CNT_W:0]   cnt_sum;
    logic [CNT_W-1:0] cnt_step;
    logic [LEN_W-1:0] rem_after;
    logic             emit_step;
    logic             emit_fl;

    // one packing step
    always_comb
    begin
        room = 4'd8 - {1'b0, off_reg};
        if (seg_len_reg < LEN_W'(room))
        begin
            n = seg_len_reg[3:0];
        end
        else
        begin
            n = room;
        end
        mask      = 8'((9'h001 << n) - 9'h001);
        ins       = 8'((seg_val_reg[7:0] & mask) << off_reg);
        part_new  = part_reg | ins;
        off_sum   = {1'b0, off_reg} + n;
        cnt_sum   = {1'b0, cnt_reg} + (CNT_W+1)'(n);
        cnt_step  = (cnt_sum > {1'b0, CNT_MAX}) ? CNT_MAX : cnt_sum[CNT_W-1:0];
        rem_after = rem_reg - LEN_W'(n);
        emit_step = ctl.step && off_sum[3];
        emit_fl   = ctl.flush && (off_reg != 3'd0);
    end

    always_comb
    begin
        sts.out_free = !ov_reg || dout.ready;
        sts.seg_last = (seg_len_reg <= LEN_W'(room));
        sts.off_zero = (off_reg == 3'd0);
    end

    always_comb
    begin
        part_next    = part_reg;
        off_next     = off_reg;
        cnt_next     = cnt_reg;
        seg_val_next = seg_val_reg;
        seg_len_next = seg_len_reg;
        rem_next     = rem_reg;
        ov_next      = ov_reg && !dout.ready;
        ob_next      = ob_reg;
        ol_next      = ol_reg;
        oe_next      = oe_reg;
        obw_next     = obw_reg;

        if (ctl.load_seg)
        begin
            seg_val_next = ctl.seg_val;
            seg_len_next = ctl.seg_len;
        end
        if (ctl.load_rem)
        begin
            rem_next = ctl.rem;
        end

        if (ctl.step)
        begin
            seg_val_next = seg_val_reg >> n;
            seg_len_next = seg_len_reg - LEN_W'(n);
            rem_next     = rem_after;
            cnt_next     = cnt_step;
            if (off_sum[3])
            begin
                part_next = '0;
                off_next  = '0;
            end
            else
            begin
                part_next = part_new;
                off_next  = off_sum[2:0];
            end
        end

        if (emit_step)
        begin
            ov_next  = 1'b1;
            ob_next  = part_new;
            ol_next  = (rem_after < LEN_W'(8));
            oe_next  = 1'b0;
            obw_next = cnt_step;
        end

        if (ctl.flush)
        begin
            part_next = '0;
            off_next  = '0;
            cnt_next  = '0;
        end

        if (emit_fl)
        begin
            ov_next  = 1'b1;
            ob_next  = part_reg;
            ol_next  = 1'b1;
            oe_next  = 1'b1;
            obw_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_reg    <= '0;
            off_reg     <= '0;
            cnt_reg     <= '0;
            seg_len_reg <= '0;
            rem_reg     <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            part_reg    <= part_next;
            off_reg     <= off_next;
            cnt_reg     <= cnt_next;
            seg_len_reg <= seg_len_next;
            rem_reg     <= rem_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seg_val_reg <= seg_val_next;
        ob_reg      <= ob_next;
        ol_reg      <= ol_next;
        oe_reg      <= oe_next;
        obw_reg     <= obw_next;
    end

    assign dout.valid        = ov_reg;
    assign dout.out_byte     = ob_reg;
    assign dout.last         = ol_reg;
    assign dout.message_end  = oe_reg;
    assign dout.bits_written = obw_reg;

endmodule
